// ----- rtl/core/lbz_pkg.sv -----
// shared types and constants of the z-axis lorentz boost
package lbz_pkg;

  // configuration register indexes
  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  localparam logic [31:0] GammaReset = 32'h1000_0000;
  localparam logic [30:0] BetaReset  = 31'd0;

  // opcode bit meanings
  localparam int OpBitToLab = 0;
  localparam int OpBitMass  = 1;

  // pipeline stage positions
  localparam int SqrtSteps = 32;
  localparam int StSq      = 1;
  localparam int StSumA    = 2;
  localparam int StSum     = 3;
  localparam int StRoot0   = 4;
  localparam int StEnergy  = StRoot0 + SqrtSteps;
  localparam int StBeta    = StEnergy + 1;
  localparam int StRound   = StBeta + 1;
  localparam int StDiff    = StRound + 1;
  localparam int StMag     = StDiff + 1;
  localparam int StProd    = StMag + 1;
  localparam int NumStages = StProd + 1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        em;
  } lbz_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] energy;
  } lbz_result_t;

endpackage

// ----- rtl/core/lorentz_boost_z_top.sv -----
// lorentz boost along z: pipelined energy rebuild, beta and gamma products
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: px, py, pz, energy_or_mass; tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: px, py, pz, energy
// cfg       in   cfg_we_i (no wait)            cfg_idx_i selects gamma or beta
//
// one beat per cycle sustained while the output is not stalled; the pipeline is made of
// the 32 stage square root pipeline plus the multiply and round stages
// reset clears all valid bits, including those of the output and skid registers, and loads gamma 1.0, beta 0
// a stalled output fills the skid register; only then does s_axis_tready drop and
// the whole pipeline holds
module lorentz_boost_z_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // in_px, in_py, in_pz, in_energy_or_mass, zero pad
  input  logic [1:0]    s_axis_tuser,   // opcode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // out_px, out_py, out_pz, out_energy
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);
  import lbz_pkg::*;

  // configuration registers
  logic [31:0] gamma_q;
  logic [30:0] beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
      beta_q  <= BetaReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GAMMA) gamma_q <= cfg_data_i;
      else                        beta_q  <= cfg_data_i[30:0];
    end
  end

  // pipeline advances whenever the skid register is empty
  logic en;
  logic skid_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  logic [NumStages-1:0] vld_q;
  lbz_item_t            item_q [NumStages];
  lbz_item_t            item_in;

  assign item_in.op = s_axis_tuser;
  assign item_in.px = s_axis_tdata[31:0];
  assign item_in.py = s_axis_tdata[63:32];
  assign item_in.pz = s_axis_tdata[95:64];
  assign item_in.em = s_axis_tdata[126:96];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // item fields ride along with every stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q[0] <= item_in;
      for (int k = 1; k < NumStages; k++) begin
        item_q[k] <= item_q[k-1];
      end
    end
  end

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // squares of the component magnitudes
  logic [63:0] sq_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= 64'(abs32(item_q[StSq-1].px)) * 64'(abs32(item_q[StSq-1].px));
      sq_q[1] <= 64'(abs32(item_q[StSq-1].py)) * 64'(abs32(item_q[StSq-1].py));
      sq_q[2] <= 64'(abs32(item_q[StSq-1].pz)) * 64'(abs32(item_q[StSq-1].pz));
      sq_q[3] <= 64'(item_q[StSq-1].em) * 64'(item_q[StSq-1].em);
    end
  end

  // sum of squares, two adds deep; the total stays below 2^64
  logic [63:0] suma_q, sumb_q, sum_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      suma_q <= sq_q[0] + sq_q[1];
      sumb_q <= sq_q[2] + sq_q[3];
      sum_q  <= suma_q + sumb_q;
    end
  end

  // restoring square root, one result bit per stage
  logic [63:0] rem_q  [SqrtSteps];
  logic [63:0] root_q [SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_root
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
    logic [63:0] rem_in, root_in;
    logic [64:0] trial;
    logic        take;

    assign rem_in  = (j == 0) ? sum_q : rem_q[(j == 0) ? 0 : j - 1];
    assign root_in = (j == 0) ? 64'd0 : root_q[(j == 0) ? 0 : j - 1];
    assign trial   = {1'b0, root_in} + {1'b0, Bit};
    assign take    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (take) begin
          rem_q[j]  <= rem_in - trial[63:0];
          root_q[j] <= (root_in >> 1) + Bit;
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in >> 1;
        end
      end
    end
  end

  // energy: rounded root in the mass modes, the input otherwise
  logic [32:0] e_q;
  logic        mass_e;
  assign mass_e = item_q[StEnergy-1].op[OpBitMass];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (mass_e) begin
        e_q <= 33'(root_q[SqrtSteps-1])
             + 33'(rem_q[SqrtSteps-1] > root_q[SqrtSteps-1]);
      end else begin
        e_q <= {2'b0, item_q[StEnergy-1].em};
      end
    end
  end

  // beta products on magnitudes
  logic [63:0] pe_q;
  logic [62:0] pzb_q;
  logic [32:0] e_b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pe_q  <= 64'(beta_q) * 64'(e_q);
      pzb_q <= 63'(beta_q) * 63'(abs32(item_q[StBeta-1].pz));
      e_b_q <= e_q;
    end
  end

  // round to nearest, ties away from zero, then restore the sign
  logic        [32:0] be_q;
  logic signed [33:0] bz_q;
  logic        [32:0] e_r_q;
  logic        [31:0] bzm;
  assign bzm = 32'((pzb_q + 63'(64'd1 << 30)) >> 31);

  always_ff @(posedge clk_i) begin
    if (en) begin
      be_q  <= 33'((pe_q + (64'd1 << 30)) >> 31);
      bz_q  <= item_q[StRound-1].pz[31] ? -$signed({2'b0, bzm}) : $signed({2'b0, bzm});
      e_r_q <= e_b_q;
    end
  end

  // boost differences, signed 35 bits
  logic signed [34:0] d1_q, d2_q;
  logic signed [34:0] pz_x, be_x, e_x, bz_x;
  logic               to_lab_d;
  assign pz_x     = {{3{item_q[StDiff-1].pz[31]}}, item_q[StDiff-1].pz};
  assign be_x     = $signed({2'b0, be_q});
  assign e_x      = $signed({2'b0, e_r_q});
  assign bz_x     = {bz_q[33], bz_q};
  assign to_lab_d = item_q[StDiff-1].op[OpBitToLab];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q <= to_lab_d ? pz_x + be_x : pz_x - be_x;
      d2_q <= to_lab_d ? e_x + bz_x : e_x - bz_x;
    end
  end

  // sign and magnitude
  logic [33:0] m1_q, m2_q;
  logic        n1_q, n2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= d1_q[34];
      n2_q <= d2_q[34];
      m1_q <= d1_q[34] ? 34'(-d1_q) : 34'(d1_q);
      m2_q <= d2_q[34] ? 34'(-d2_q) : 34'(d2_q);
    end
  end

  // gamma products
  logic [65:0] p1_q, p2_q;
  logic        n1_p_q, n2_p_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= 66'(gamma_q) * 66'(m1_q);
      p2_q   <= 66'(gamma_q) * 66'(m2_q);
      n1_p_q <= n1_q;
      n2_p_q <= n2_q;
    end
  end

  // round, shift out the Q4.28 scale and saturate to signed 32 bits
  function automatic logic [31:0] round_sat(logic [65:0] p, logic neg);
    logic [37:0] mag;
    mag = 38'((p + 66'(64'd1 << 27)) >> 28);
    if (neg) begin
      if (mag > 38'h0_8000_0000) mag = 38'h0_8000_0000;
      return 32'(-mag);
    end
    if (mag > 38'h0_7FFF_FFFF) mag = 38'h0_7FFF_FFFF;
    return mag[31:0];
  endfunction

  lbz_result_t res_new;
  assign res_new.px     = item_q[StProd].px;
  assign res_new.py     = item_q[StProd].py;
  assign res_new.pz     = round_sat(p1_q, n1_p_q);
  assign res_new.energy = item_q[StProd].op[OpBitMass] ? 32'd0 : round_sat(p2_q, n2_p_q);

  // output register with one skid entry
  logic        out_v_q;
  lbz_result_t out_q, skid_q;
  logic        leaving, out_free;
  assign leaving  = vld_q[NumStages-1] && en;
  assign out_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (leaving) begin
      if (out_free) out_v_q  <= 1'b1;
      else          skid_v_q <= 1'b1;
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) out_q <= skid_q;
    end else if (leaving) begin
      if (out_free) out_q  <= res_new;
      else          skid_q <= res_new;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.energy, out_q.pz, out_q.py, out_q.px};

endmodule

// ----- rtl/core/lbz_check.sv -----
// port-level checks of the lorentz boost block and their bind
module lbz_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [127:0]  m_axis_tdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // input backpressure only when a result is stuck
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input ready dropped without output stall");

  // a full skid implies a waiting output beat
  a_ready_low_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input not ready while output empty");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

bind lorentz_boost_z_top lbz_check u_lbz_check (.*);

// ----- dv/tb.sv -----
// testbench for the z-axis lorentz boost: predicts each boosted four-vector and checks the stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbz_pkg::*;

  localparam int Latency = 43;
  localparam int WatchLimit = 20000;

  // opcode values: bit 0 selects cm to lab, bit 1 selects mass mode
  typedef enum logic [1:0] {
    OP_TO_CM_E   = 2'd0,
    OP_TO_LAB_E  = 2'd1,
    OP_TO_CM_M   = 2'd2,
    OP_TO_LAB_M  = 2'd3
  } boost_op_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;   // in_px, in_py, in_pz, in_energy_or_mass, zero pad
  logic [1:0]    s_axis_tuser = '0;   // opcode
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [127:0]  m_axis_tdata;        // out_px, out_py, out_pz, out_energy
  logic          cfg_we_i = 1'b0;
  logic          cfg_idx_i = 1'b0;
  logic [31:0]   cfg_data_i = '0;

  lorentz_boost_z_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor's copy of the registers
  logic [31:0] gamma_q = GammaReset;
  logic [30:0] beta_q  = BetaReset;

  lbz_result_t boosted_q[$];
  int          n_mismatch = 0;
  int          idle_cycles = 0;
  bit          hold_rx = 1'b0;   // long receiver hold-off
  int          rx_gap_max = 3;

  // nearest-rounded integer square root
  function automatic logic [63:0] isqrt_near(logic [63:0] v);
    logic [63:0] rem, r, b;
    rem = v; r = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (rem > r) r++;
    return r;
  endfunction

  // round(beta * x / 2^31), ties away from zero on the magnitude
  function automatic longint beta_scale(longint x);
    logic [63:0] m, p;
    m = (x < 0) ? -x : x;
    p = ({33'd0, beta_q} * m + (64'd1 << 30)) >> 31;
    return (x < 0) ? -longint'(p) : longint'(p);
  endfunction

  // round(gamma * d / 2^28), saturated to signed 32 bits
  function automatic logic [31:0] gamma_scale(longint d);
    logic [127:0] prod;
    logic [63:0]  m;
    m = (d < 0) ? -d : d;
    prod = ({64'd0, m} * {96'd0, gamma_q} + (128'd1 << 27)) >> 28;
    if (d < 0) begin
      if (prod > 128'h8000_0000) prod = 128'h8000_0000;
      return -prod[31:0];
    end
    if (prod > 128'h7FFF_FFFF) prod = 128'h7FFF_FFFF;
    return prod[31:0];
  endfunction

  function automatic lbz_result_t boost_vector(boost_op_e op, logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz, logic [30:0] em);
    lbz_result_t r;
    longint e, be, bz, xp, yp, zp, mm;
    bit to_lab, mass;
    to_lab = op[OpBitToLab];
    mass = op[OpBitMass];
    xp = px; yp = py; zp = pz; mm = em;
    if (mass)
      e = longint'(isqrt_near(xp * xp + yp * yp + zp * zp + mm * mm));
    else
      e = mm;
    be = beta_scale(e);
    r.px = px;
    r.py = py;
    r.pz = gamma_scale(to_lab ? zp + be : zp - be);
    if (mass) begin
      r.energy = '0;
    end else begin
      bz = beta_scale(zp);
      r.energy = gamma_scale(to_lab ? e + bz : e - bz);
    end
    return r;
  endfunction

  function automatic int pick_gap(int maxlong);
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, maxlong);
    return $urandom_range(0, 2);
  endfunction

  // send one beat; the expectation is pushed as it is accepted
  task automatic send_vector(boost_op_e op, logic [31:0] px, logic [31:0] py,
      logic [31:0] pz, logic [30:0] em, bit gaps = 1);
    int g;
    g = gaps ? pick_gap(30) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, em, pz, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    boosted_q.push_back(boost_vector(op, px, py, pz, em));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for the pipeline to drain, then let its latency pass
  task automatic drain();
    stop_sending();
    while (boosted_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GAMMA) gamma_q = val;
    else beta_q = val[30:0];
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_mom();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 4000) - 2000;
      3: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_em();
    case ($urandom_range(0, 4))
      0: return 31'h7FFF_FFFF;
      1: return 31'd0;
      2: return 31'($urandom_range(0, 32'h00FF_FFFF));
      default: return 31'($urandom);
    endcase
  endfunction

  // extremes of every field under each opcode, plus the special cases
  task automatic test_directed();
    boost_op_e op;
    for (int o = 0; o < 4; o++) begin
      op = boost_op_e'(o);
      send_vector(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 0);
      send_vector(op, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_vector(op, 0, 0, 0, 0, 0);
      send_vector(op, 32'd100, -32'sd100, 32'd5000, 31'd3000, 0);
    end
    // unphysical: momentum far above energy, so with a large enough beta the boosted energy goes negative
    send_vector(OP_TO_CM_E, 0, 0, 32'h4000_0000, 31'd16, 0);
    send_vector(OP_TO_LAB_E, 0, 0, 32'hC000_0000, 31'd16, 0);
    drain();
  endtask

  task automatic run_random(int n, bit mass_only = 0);
    boost_op_e op;
    for (int i = 0; i < n; i++) begin
      op = boost_op_e'($urandom_range(0, 3));
      if (mass_only) op = boost_op_e'({1'b1, op[0]});
      send_vector(op, rand_mom(), rand_mom(), rand_mom(), rand_em());
    end
    drain();
  endtask

  // several register settings including the extremes
  task automatic test_settings();
    logic [31:0] gammas[6];
    logic [31:0] betas[6];
    gammas = '{32'h1000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0800_0000, 32'h1400_0000, 32'h0};
    betas  = '{32'h0, 32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'h6000_0000, 32'h7FFF_FFFF};
    for (int k = 0; k < 6; k++) begin
      write_reg(CFG_GAMMA, gammas[k]);
      write_reg(CFG_BETA, betas[k]);
      if (k == 5) begin
        write_reg(CFG_GAMMA, $urandom_range(32'h1000_0000, 32'hFFFF_FFFF));
        write_reg(CFG_BETA, $urandom & 32'h7FFF_FFFF);
      end
      test_directed();
      run_random(160);
    end
  endtask

  // random boosts with gamma between 1.0 and 3.0 and random beta; every other run uses mass modes only
  task automatic test_random_boosts();
    for (int k = 0; k < 6; k++) begin
      write_reg(CFG_GAMMA, $urandom_range(32'h1000_0000, 32'h3000_0000));
      write_reg(CFG_BETA, $urandom & 32'h7FFF_FFFF);
      run_random(100, k[0]);
    end
  endtask

  // receiver holds off long enough that the pipeline fills and s_axis_tready drops
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (Latency * 3) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 150; i++)
        send_vector(boost_op_e'($urandom_range(0, 3)), rand_mom(), rand_mom(), rand_mom(),
                    rand_em(), 0);
    join
    drain();
  endtask

  // receiver: random stalls, stretches without stalls
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end else begin
        g = pick_gap(rx_gap_max);
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    lbz_result_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px     = m_axis_tdata[31:0];
      got.py     = m_axis_tdata[63:32];
      got.pz     = m_axis_tdata[95:64];
      got.energy = m_axis_tdata[127:96];
      if (boosted_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        exp_r = boosted_q.pop_front();
        if (got.px !== exp_r.px || got.py !== exp_r.py || got.pz !== exp_r.pz ||
            got.energy !== exp_r.energy) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch px %h/%h py %h/%h pz %h/%h e %h/%h (exp/got)",
                     exp_r.px, got.px, exp_r.py, got.py, exp_r.pz, got.pz,
                     exp_r.energy, got.energy);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();        // reset registers: gamma 1.0, beta 0
    test_settings();
    test_random_boosts();
    rx_gap_max = 40;
    test_backpressure();
    if (n_mismatch == 0 && boosted_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// ----- lorentz_boost_z_top.f -----
rtl/core/lbz_pkg.sv
rtl/core/lorentz_boost_z_top.sv
rtl/core/lbz_check.sv
dv/tb.sv
